// ===== rtl/usp_pkg.sv =====
// ----------------------------------------------------------------------------
// usp_pkg
// Shared types and constants of the unit-step plateau increment block.
// ----------------------------------------------------------------------------
package usp_pkg;

    localparam int INDEX_W   = 6;
    localparam int LEN_W     = 7;
    localparam int POS_OUT_W = 7;
    localparam int READ_W    = 16;

    typedef logic [INDEX_W-1:0]   index_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [POS_OUT_W-1:0] pos_out_t;
    typedef logic [READ_W-1:0]    read_t;

    localparam len_t LEN_RESET = len_t'(64);

    typedef enum logic
    {
        OP_READ = 1'b0,
        OP_INC  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK       = 2'd0,
        STATUS_RANGE    = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    // broadcast from the controller to every cell
    typedef struct packed
    {
        logic   clear;
        logic   inc;
        index_t index;
    } cell_ctrl_t;

endpackage

// ===== rtl/usp_if.sv =====
// ----------------------------------------------------------------------------
// usp channel interfaces
// Valid/ready channels for commands, results and the length register.
// ----------------------------------------------------------------------------
interface usp_cmd_if;
    logic            valid;
    logic            ready;
    logic            op;
    usp_pkg::index_t index;

    modport source (output valid, output op, output index, input ready);
    modport sink   (input valid, input op, input index, output ready);
endinterface

interface usp_res_if;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    usp_pkg::read_t    value_read;
    usp_pkg::pos_out_t merged_begin;
    usp_pkg::pos_out_t changed_begin;
    usp_pkg::pos_out_t run_end;

    modport source (output valid, output status, output value_read, output merged_begin,
                    output changed_begin, output run_end, input ready);
    modport sink   (input valid, input status, input value_read, input merged_begin,
                    input changed_begin, input run_end, output ready);
endinterface

interface usp_cfg_if;
    logic          valid;
    logic          ready;
    usp_pkg::len_t seq_length;

    modport source (output valid, output seq_length, input ready);
    modport sink   (input valid, input seq_length, output ready);
endinterface

// ===== rtl/unit_step_plateau_increment.sv =====
// ----------------------------------------------------------------------------
// unit_step_plateau_increment
// Non-increasing unit-step counter sequence with plateau increment.
// ----------------------------------------------------------------------------
// cmd carries op and index; a read returns the element value, an increment
// raises the plateau holding index from its start through index and returns
// the merged plateau start, the first raised index and index plus one.
// res carries one result per command transaction. cfg writes seq_length,
// which also clears every element to zero; it is always ready.
// The accept cycle reads the addressed cell through a broadcast select;
// the execute state then compares every cell against that value, locates
// the plateau edges along the cell row and writes back.
// The result is registered when the execute state ends; one command is in
// flight at a time, so no new command is accepted until that one has finished.
// Reset clears all elements to zero and sets seq_length to 64.
// A result stays in the output register until taken; while res is stalled
// the block holds the pending command and accepts no further one.
// ----------------------------------------------------------------------------
module unit_step_plateau_increment #(
    parameter int MAX_SIZE    = 64,
    parameter int VALUE_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    usp_cmd_if.sink      cmd,
    usp_res_if.source    res,
    usp_cfg_if.sink      cfg
);

    localparam int POS_W = $clog2(MAX_SIZE);

    typedef enum logic
    {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                     state_reg;
    logic                       op_reg;
    usp_pkg::index_t            idx_reg;
    logic [VALUE_WIDTH-1:0]     old_reg;
    logic                       range_ok_reg;
    usp_pkg::len_t              len_reg;

    logic                       res_valid_reg;
    usp_pkg::status_t           status_reg;
    usp_pkg::read_t             value_read_reg;
    usp_pkg::pos_out_t          merged_reg;
    usp_pkg::pos_out_t          changed_reg;
    usp_pkg::pos_out_t          end_reg;

    usp_pkg::status_t           status_next;
    usp_pkg::read_t             value_read_next;
    usp_pkg::pos_out_t          merged_next;
    usp_pkg::pos_out_t          changed_next;
    usp_pkg::pos_out_t          end_next;

    usp_pkg::cell_ctrl_t        cell_ctrl;
    logic [VALUE_WIDTH-1:0]     sel_values [MAX_SIZE];
    logic [MAX_SIZE-1:0]        gt_flags;
    logic [MAX_SIZE-1:0]        gt2_flags;
    logic [MAX_SIZE-1:0]        gt_left;
    logic [MAX_SIZE-1:0]        gt2_left;
    logic [MAX_SIZE-1:0]        start_hits;
    logic [MAX_SIZE-1:0]        merge_hits;

    logic [MAX_SIZE-1:0]        read_plane  [VALUE_WIDTH];
    logic [MAX_SIZE-1:0]        start_plane [POS_W];
    logic [MAX_SIZE-1:0]        merge_plane [POS_W];
    logic [VALUE_WIDTH-1:0]     read_value;
    logic [POS_W-1:0]           start_pos;
    logic [POS_W-1:0]           merge_pos;

    logic                       accept;
    logic                       out_free;
    logic                       overflow;
    logic                       do_inc;
    logic                       in_range;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !res_valid_reg || res.ready;

    assign in_range = ({1'b0, cmd.index} < len_reg) && (int'(cmd.index) < MAX_SIZE);
    assign overflow = &old_reg;
    assign do_inc   = (state_reg == S_EXEC) && out_free && range_ok_reg
                      && (op_reg == usp_pkg::OP_INC) && !overflow;

    assign cell_ctrl.clear = cfg.valid && cfg.ready;
    assign cell_ctrl.inc   = do_inc;
    assign cell_ctrl.index = (state_reg == S_IDLE) ? cmd.index : idx_reg;

    // neighbour hand-off of the compare flags along the row
    generate
        if (MAX_SIZE > 1)
        begin : g_chain
            assign gt_left  = {gt_flags[MAX_SIZE-2:0], 1'b1};
            assign gt2_left = {gt2_flags[MAX_SIZE-2:0], 1'b1};
        end
        else
        begin : g_single
            assign gt_left  = 1'b1;
            assign gt2_left = 1'b1;
        end
    endgenerate

    generate
        for (genvar j = 0; j < MAX_SIZE; j++)
        begin : g_cell
            usp_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .POS         (j)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .old_value (old_reg),
                .gt_left   (gt_left[j]),
                .gt2_left  (gt2_left[j]),
                .gt        (gt_flags[j]),
                .gt2       (gt2_flags[j]),
                .start_hit (start_hits[j]),
                .merge_hit (merge_hits[j]),
                .sel_value (sel_values[j])
            );
        end
    endgenerate

    // bit planes reduced by or: selected value and one-hot position encode
    always_comb
    begin
        logic [POS_W-1:0] pos_bits;
        for (int b = 0; b < VALUE_WIDTH; b++)
        begin
            for (int j = 0; j < MAX_SIZE; j++)
            begin
                read_plane[b][j] = sel_values[j][b];
            end
            read_value[b] = |read_plane[b];
        end
        for (int b = 0; b < POS_W; b++)
        begin
            for (int j = 0; j < MAX_SIZE; j++)
            begin
                pos_bits           = POS_W'(j);
                start_plane[b][j]  = start_hits[j] & pos_bits[b];
                merge_plane[b][j]  = merge_hits[j] & pos_bits[b];
            end
            start_pos[b] = |start_plane[b];
            merge_pos[b] = |merge_plane[b];
        end
    end

    always_comb
    begin
        status_next     = usp_pkg::STATUS_OK;
        value_read_next = '0;
        merged_next     = '0;
        changed_next    = '0;
        end_next        = '0;
        if (!range_ok_reg)
        begin
            status_next = usp_pkg::STATUS_RANGE;
        end
        else if (op_reg == usp_pkg::OP_READ)
        begin
            value_read_next = usp_pkg::read_t'(old_reg);
        end
        else if (overflow)
        begin
            status_next     = usp_pkg::STATUS_OVERFLOW;
            value_read_next = usp_pkg::read_t'(old_reg);
        end
        else
        begin
            value_read_next = usp_pkg::read_t'(old_reg + 1'b1);
            merged_next     = usp_pkg::pos_out_t'(merge_pos);
            changed_next    = usp_pkg::pos_out_t'(start_pos);
            end_next        = usp_pkg::pos_out_t'(idx_reg) + usp_pkg::pos_out_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= usp_pkg::LEN_RESET;
            op_reg         <= 1'b0;
            idx_reg        <= '0;
            old_reg        <= '0;
            range_ok_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            status_reg     <= usp_pkg::STATUS_OK;
            value_read_reg <= '0;
            merged_reg     <= '0;
            changed_reg    <= '0;
            end_reg        <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                len_reg <= cfg.seq_length;
            end
            if (res.ready && (state_reg != S_EXEC))
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg    <= S_EXEC;
                        op_reg       <= cmd.op;
                        idx_reg      <= cmd.index;
                        old_reg      <= read_value;
                        range_ok_reg <= in_range;
                    end
                end
                S_EXEC:
                begin
                    if (out_free)
                    begin
                        state_reg      <= S_IDLE;
                        res_valid_reg  <= 1'b1;
                        status_reg     <= status_next;
                        value_read_reg <= value_read_next;
                        merged_reg     <= merged_next;
                        changed_reg    <= changed_next;
                        end_reg        <= end_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.status        = status_reg;
    assign res.value_read    = value_read_reg;
    assign res.merged_begin  = merged_reg;
    assign res.changed_begin = changed_reg;
    assign res.run_end       = end_reg;

    // plateau edges along the row are unique while a command executes
    a_start_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $onehot(start_hits))
        else $error("plateau start edge not unique");

    a_merge_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $onehot(merge_hits))
        else $error("merged plateau edge not unique");

    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (status_reg == usp_pkg::STATUS_OK) && (end_reg != '0))
        |-> ((merged_reg <= changed_reg) && (changed_reg < end_reg)))
        else $error("raised span out of order");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (status_reg == usp_pkg::STATUS_RANGE))
        |-> ((value_read_reg == '0) && (end_reg == '0) && (changed_reg == '0)))
        else $error("out-of-range result carries data");

    a_no_write_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        do_inc |-> out_free)
        else $error("cells written while the result is stalled");

endmodule

// ===== rtl/usp_cell.sv =====
// ----------------------------------------------------------------------------
// usp_cell
// One sequence element: holds its counter, compares it against the broadcast
// value and passes its compare flags on to the right-hand neighbour.
// ----------------------------------------------------------------------------
module usp_cell #(
    parameter int VALUE_WIDTH = 16,
    parameter int POS         = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  usp_pkg::cell_ctrl_t     ctrl,
    input  logic [VALUE_WIDTH-1:0]  old_value,
    input  logic                    gt_left,
    input  logic                    gt2_left,
    output logic                    gt,
    output logic                    gt2,
    output logic                    start_hit,
    output logic                    merge_hit,
    output logic [VALUE_WIDTH-1:0]  sel_value
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   at_or_below;
    logic                   selected;
    logic                   raise;

    assign at_or_below = (POS <= int'(ctrl.index));
    assign selected    = (POS == int'(ctrl.index));

    assign gt  = (value_reg > old_value);
    assign gt2 = ({1'b0, value_reg} > ({1'b0, old_value} + 1'b1));

    // thermometer edges mark the plateau starts
    assign start_hit = gt_left & ~gt;
    assign merge_hit = gt2_left & ~gt2;

    assign sel_value = selected ? value_reg : '0;

    assign raise = ctrl.inc && (value_reg == old_value) && at_or_below;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.clear)
        begin
            value_next = '0;
        end
        else if (raise)
        begin
            value_next = value_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

endmodule

// ===== sim/tb_unit_step_plateau_increment.sv =====
// ----------------------------------------------------------------------------
// tb_unit_step_plateau_increment
// Self-checking bench for the unit-step plateau increment sequence.
// ----------------------------------------------------------------------------
// A clocked driver offers read and increment commands from a backlog that the
// stimulus process fills. A clocked monitor predicts each accepted command
// against its own copy of the counter row and checks every result
// transaction field by field. The run covers directed corner cases and
// random traffic over several lengths. Sender and receiver idle at varied
// rates, and a long receiver hold-off backs up the command path.
// ----------------------------------------------------------------------------
module tb_unit_step_plateau_increment;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CELLS      = 64;
    localparam int VALUE_BITS     = 16;
    localparam int CYCLE_LIMIT    = 200_000;
    localparam int HOLDOFF_CYCLES = 300;

    localparam logic [VALUE_BITS-1:0] VALUE_TOP = '1;

    typedef struct
    {
        usp_pkg::op_t    op;
        usp_pkg::index_t index;
    } command_t;

    typedef struct
    {
        usp_pkg::status_t  status;
        usp_pkg::read_t    value;
        usp_pkg::pos_out_t merged_begin;
        usp_pkg::pos_out_t changed_begin;
        usp_pkg::pos_out_t run_end;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n;

    usp_cmd_if cmd_ch ();
    usp_res_if res_ch ();
    usp_cfg_if cfg_ch ();

    unit_step_plateau_increment #(
        .MAX_SIZE    (MAX_CELLS),
        .VALUE_WIDTH (VALUE_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // model of the counter row
    logic [VALUE_BITS-1:0] cell_value [MAX_CELLS];
    usp_pkg::len_t         seq_len;

    command_t command_backlog [$];
    reply_t   pending_replies [$];

    int cmd_offered     = 0;
    int cmd_accepted    = 0;
    int commands_queued = 0;
    int results_taken   = 0;
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    logic res_hold      = 1'b0;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int reads_done     = 0;
    int raises_done    = 0;
    int range_hits     = 0;
    int overflow_hits  = 0;
    int length_writes  = 0;
    int top_value      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int unsigned plateau_begin(int unsigned pos);
        int unsigned j;
        j = pos;
        while (j > 0 && cell_value[j-1] == cell_value[pos])
            j--;
        return j;
    endfunction

    function automatic reply_t plateau_step(usp_pkg::op_t op, usp_pkg::index_t idx);
        reply_t                r;
        logic [VALUE_BITS-1:0] old;
        int unsigned           active;
        int unsigned           start;
        int unsigned           k;
        r.status        = usp_pkg::STATUS_OK;
        r.value         = '0;
        r.merged_begin  = '0;
        r.changed_begin = '0;
        r.run_end       = '0;
        active = (seq_len > MAX_CELLS) ? MAX_CELLS : seq_len;
        if (idx >= active)
            r.status = usp_pkg::STATUS_RANGE;
        else if (op == usp_pkg::OP_READ)
            r.value = usp_pkg::read_t'(cell_value[idx]);
        else
        begin
            old = cell_value[idx];
            if (old == VALUE_TOP)
            begin
                r.status = usp_pkg::STATUS_OVERFLOW;
                r.value  = usp_pkg::read_t'(old);
            end
            else
            begin
                start          = plateau_begin(idx);
                r.merged_begin = usp_pkg::pos_out_t'(start);
                if (start > 0 && cell_value[start-1] == old + 1'b1)
                    r.merged_begin = usp_pkg::pos_out_t'(plateau_begin(start - 1));
                for (k = start; k <= idx; k++)
                    cell_value[k] = old + 1'b1;
                r.changed_begin = usp_pkg::pos_out_t'(start);
                r.run_end       = usp_pkg::pos_out_t'(idx + 1);
                r.value         = usp_pkg::read_t'(old + 1'b1);
            end
        end
        return r;
    endfunction

    // command driver
    always @(negedge clk)
    begin
        command_t c;
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.op    <= usp_pkg::OP_READ;
            cmd_ch.index <= '0;
        end
        else if (!(cmd_ch.valid && cmd_offered != cmd_accepted))
        begin
            if (command_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                c = command_backlog.pop_front();
                cmd_ch.valid <= 1'b1;
                cmd_ch.op    <= c.op;
                cmd_ch.index <= c.index;
                cmd_offered  <= cmd_offered + 1;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // result ready
    always @(negedge clk)
    begin
        res_ch.ready <= rst_n && !res_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        reply_t want;
        if (!rst_n)
        begin
            seq_len = usp_pkg::LEN_RESET;
            foreach (cell_value[i])
                cell_value[i] = '0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_taken <= results_taken + 1;
                if (pending_replies.size() == 0)
                    report_mismatch("result transaction with no command outstanding");
                else
                begin
                    want = pending_replies.pop_front();
                    if (res_ch.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  res_ch.status, want.status));
                    if (res_ch.value_read !== want.value)
                        report_mismatch($sformatf("value_read got %0d expected %0d",
                                                  res_ch.value_read, want.value));
                    if (res_ch.merged_begin !== want.merged_begin)
                        report_mismatch($sformatf("merged_begin got %0d expected %0d",
                                                  res_ch.merged_begin, want.merged_begin));
                    if (res_ch.changed_begin !== want.changed_begin)
                        report_mismatch($sformatf("changed_begin got %0d expected %0d",
                                                  res_ch.changed_begin, want.changed_begin));
                    if (res_ch.run_end !== want.run_end)
                        report_mismatch($sformatf("run_end got %0d expected %0d",
                                                  res_ch.run_end, want.run_end));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                seq_len = cfg_ch.seq_length;
                foreach (cell_value[i])
                    cell_value[i] = '0;
                length_writes++;
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                cmd_accepted <= cmd_accepted + 1;
                want = plateau_step(usp_pkg::op_t'(cmd_ch.op), cmd_ch.index);
                pending_replies.push_back(want);
                case (want.status)
                    usp_pkg::STATUS_RANGE:    range_hits++;
                    usp_pkg::STATUS_OVERFLOW: overflow_hits++;
                    default:
                    begin
                        if (cmd_ch.op == usp_pkg::OP_READ)
                            reads_done++;
                        else
                            raises_done++;
                    end
                endcase
                if (want.value > top_value)
                    top_value = want.value;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles without draining", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // returns at a rising edge
    task automatic wait_drained;
        do
            @(negedge clk);
        while (!(commands_queued == results_taken && cmd_offered == cmd_accepted));
        @(posedge clk);
    endtask

    task automatic queue_command(usp_pkg::op_t op, usp_pkg::index_t idx);
        command_t c;
        c.op    = op;
        c.index = idx;
        command_backlog.push_back(c);
        commands_queued++;
    endtask

    task automatic queue_random(usp_pkg::len_t len);
        int unsigned     active;
        usp_pkg::op_t    op;
        usp_pkg::index_t idx;
        active = (len > MAX_CELLS) ? MAX_CELLS : len;
        op = ($urandom_range(99) < 60) ? usp_pkg::OP_INC : usp_pkg::OP_READ;
        if (active == 0 || $urandom_range(99) < 12)
            idx = usp_pkg::index_t'($urandom_range(63));
        else
            idx = usp_pkg::index_t'($urandom_range(active - 1));
        queue_command(op, idx);
    endtask

    task automatic write_length(usp_pkg::len_t len);
        wait_drained;
        @(negedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.seq_length <= len;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(usp_pkg::len_t len, int idle, int stall, int count);
        write_length(len);
        sender_idle_pct <= idle;
        sink_stall_pct  <= stall;
        repeat (count)
            queue_random(len);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.seq_length = usp_pkg::LEN_RESET;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full row from reset
        queue_command(usp_pkg::OP_READ, 6'd0);
        queue_command(usp_pkg::OP_READ, 6'd63);
        queue_command(usp_pkg::OP_INC, 6'd63);
        queue_command(usp_pkg::OP_INC, 6'd0);
        queue_command(usp_pkg::OP_INC, 6'd5);
        queue_command(usp_pkg::OP_READ, 6'd5);
        queue_command(usp_pkg::OP_INC, 6'd63);
        queue_command(usp_pkg::OP_INC, 6'd40);
        queue_command(usp_pkg::OP_READ, 6'd0);

        write_length(usp_pkg::len_t'(1));
        queue_command(usp_pkg::OP_INC, 6'd0);
        queue_command(usp_pkg::OP_READ, 6'd0);
        queue_command(usp_pkg::OP_READ, 6'd1);
        queue_command(usp_pkg::OP_INC, 6'd63);

        // empty row, everything out of range
        write_length(usp_pkg::len_t'(0));
        queue_command(usp_pkg::OP_READ, 6'd0);
        queue_command(usp_pkg::OP_INC, 6'd0);
        queue_command(usp_pkg::OP_INC, 6'd63);

        // length beyond the row size
        write_length(usp_pkg::len_t'(127));
        queue_command(usp_pkg::OP_READ, 6'd63);
        queue_command(usp_pkg::OP_INC, 6'd63);
        queue_command(usp_pkg::OP_INC, 6'd62);
        queue_command(usp_pkg::OP_READ, 6'd0);

        random_phase(usp_pkg::len_t'(64), 0, 0, 60);
        random_phase(usp_pkg::len_t'(8), 78, 0, 60);
        random_phase(usp_pkg::len_t'(64), 0, 78, 60);
        random_phase(usp_pkg::len_t'($urandom_range(63, 2)), 34, 34, 60);

        // long receiver hold-off while commands keep coming
        write_length(usp_pkg::len_t'(2));
        sender_idle_pct <= 0;
        sink_stall_pct  <= 0;
        fork
            begin
                @(posedge clk);
                res_hold = 1'b1;
                repeat (HOLDOFF_CYCLES)
                    @(posedge clk);
                res_hold = 1'b0;
            end
        join_none
        repeat (40)
            queue_random(usp_pkg::len_t'(2));

        // sender pauses mid-phase until every result is back
        random_phase(usp_pkg::len_t'(64), 34, 34, 30);
        wait_drained;
        repeat (30)
            queue_random(usp_pkg::len_t'(64));

        random_phase(usp_pkg::len_t'(127), 78, 78, 50);
        random_phase(usp_pkg::len_t'(1), 0, 0, 20);

        wait_drained;
        repeat (4)
            @(negedge clk);

        $display("checked %0d results: %0d reads, %0d raises, %0d range errors, %0d overflows",
                 results_taken, reads_done, raises_done, range_hits, overflow_hits);
        $display("%0d length writes, highest counter value %0d", length_writes, top_value);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
